### rtl/bht_pkg.sv
package bht_pkg;

  localparam int NUM_BUCKETS = 256;
  localparam int MAX_WAYS    = 8;

  localparam int KEY_W  = 32;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;
  localparam int WNOW_W = 4;

  localparam int BKT_W    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAYS_W   = $clog2(MAX_WAYS + 1);
  localparam int REM_W    = $clog2(NUM_BUCKETS + 1);
  localparam int SLOT_W   = BKT_W + WAY_W;
  localparam int SLOT_NUM = NUM_BUCKETS << WAY_W;

  // Modulo unit: four quotient bits per cycle.
  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = KEY_W / MOD_BITS;
  localparam int STEP_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int BCNT_W     = 9;
  localparam int IWAY_W     = 4;
  localparam int STEPC_W    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_WAYS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_STEP    = 2'd2;

  localparam logic [BCNT_W-1:0]  BUCKET_COUNT_RST = 9'd256;
  localparam logic [IWAY_W-1:0]  INITIAL_WAYS_RST = 4'd4;
  localparam logic [STEPC_W-1:0] WAYS_STEP_RST    = 4'd2;

  localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] name_tag;
    logic [KEY_W-1:0] elem_ref;
  } slot_t;

  typedef struct packed {
    logic                clear;
    logic                row_rd;
    logic                row_wr;
    logic [BKT_W-1:0]    row_addr;
    logic [MAX_WAYS-1:0] row_wdata;
    logic                slot_rd;
    logic                slot_wr;
    logic [SLOT_W-1:0]   slot_addr;
    slot_t               slot_wdata;
  } store_req_t;

  function automatic logic [REM_W-1:0] eff_buckets(input logic [BCNT_W-1:0] v);
    logic [REM_W-1:0] r;
    if (v == '0) r = REM_W'(1);
    else if (int'(v) > NUM_BUCKETS) r = REM_W'(NUM_BUCKETS);
    else r = REM_W'(v);
    return r;
  endfunction

  function automatic logic [WAYS_W-1:0] eff_initial(input logic [IWAY_W-1:0] v);
    logic [WAYS_W-1:0] r;
    if (v == '0) r = WAYS_W'(1);
    else if (int'(v) > MAX_WAYS) r = WAYS_W'(MAX_WAYS);
    else r = WAYS_W'(v);
    return r;
  endfunction

  // Bits of the ways below n.
  function automatic logic [MAX_WAYS-1:0] ways_mask(input logic [WAYS_W-1:0] n);
    logic [MAX_WAYS-1:0] m;
    for (int w = 0; w < MAX_WAYS; w++) begin
      m[w] = (WAYS_W'(w) < n);
    end
    return m;
  endfunction

  // Lowest set bit; the result is meaningless for an empty vector.
  function automatic logic [WAY_W-1:0] first_way(input logic [MAX_WAYS-1:0] v);
    logic [WAY_W-1:0] r;
    r = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (v[w]) r = WAY_W'(w);
    end
    return r;
  endfunction

  function automatic logic [MAX_WAYS-1:0] way_bit(input logic [WAY_W-1:0] w);
    return MAX_WAYS'(1) << w;
  endfunction

endpackage

### rtl/bht_in_if.sv
interface bht_in_if;
  logic                      valid;
  logic                      ready;
  logic [bht_pkg::OP_W-1:0]  op;
  logic [bht_pkg::KEY_W-1:0] key_hash;
  logic [bht_pkg::KEY_W-1:0] name_tag;
  logic [bht_pkg::KEY_W-1:0] element_ref;

  modport source (output valid, op, key_hash, name_tag, element_ref, input ready);
  modport sink (input valid, op, key_hash, name_tag, element_ref, output ready);
endinterface

### rtl/bht_out_if.sv
interface bht_out_if;
  logic                       valid;
  logic                       ready;
  logic [bht_pkg::STAT_W-1:0] status;
  logic [bht_pkg::KEY_W-1:0]  found_ref;
  logic [bht_pkg::WNOW_W-1:0] ways_now;

  modport source (output valid, status, found_ref, ways_now, input ready);
  modport sink (input valid, status, found_ref, ways_now, output ready);
endinterface

### rtl/bht_cfg_if.sv
interface bht_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bht_pkg::CFG_IDX_W-1:0]  index;
  logic [bht_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/bht_mod.sv
module bht_mod (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bht_pkg::KEY_W-1:0] dividend,
  input  logic [bht_pkg::REM_W-1:0] divisor,
  output logic                      done,
  output logic [bht_pkg::REM_W-1:0] rem
);
  import bht_pkg::*;

  logic [KEY_W-1:0]  dvd;
  logic [REM_W-1:0]  dsr;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic [REM_W-1:0]  rem_next;

  // Restoring remainder, one dividend bit per inner step.
  always_comb begin
    logic [REM_W:0] r_ext;
    rem_next = rem;
    for (int k = 0; k < MOD_BITS; k++) begin
      r_ext = {rem_next, dvd[KEY_W-1-k]};
      if (r_ext >= {1'b0, dsr}) r_ext = r_ext - {1'b0, dsr};
      rem_next = r_ext[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == STEP_W'(MOD_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      dvd <= dvd << MOD_BITS;
      rem <= rem_next;
      cnt <= cnt + STEP_W'(1);
    end
  end
endmodule

### rtl/bht_store.sv
module bht_store (
  input  logic                         clk,
  input  logic                         rst,
  input  bht_pkg::store_req_t          req,
  output logic [bht_pkg::MAX_WAYS-1:0] row_rdata,
  output bht_pkg::slot_t               slot_rdata
);
  import bht_pkg::*;

  logic [MAX_WAYS-1:0] row_mem [NUM_BUCKETS];
  slot_t               slot_mem [SLOT_NUM];

  // A bucket's row of valid bits counts only once written since the last clear.
  logic [NUM_BUCKETS-1:0] fresh;
  logic [MAX_WAYS-1:0]    row_q;
  logic                   fresh_q;

  always_ff @(posedge clk) begin
    if (req.row_wr) row_mem[req.row_addr] <= req.row_wdata;
    if (req.row_rd) begin
      row_q   <= row_mem[req.row_addr];
      fresh_q <= fresh[req.row_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.slot_wr) slot_mem[req.slot_addr] <= req.slot_wdata;
    if (req.slot_rd) slot_rdata <= slot_mem[req.slot_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh <= '0;
    end else if (req.clear) begin
      fresh <= '0;
    end else if (req.row_wr) begin
      fresh[req.row_addr] <= 1'b1;
    end
  end

  assign row_rdata = fresh_q ? row_q : '0;
endmodule

### rtl/bucketed_hash_table.sv
// Items are taken one at a time: clear goes straight to the result, add writes
// at most one way of the bucket's row, and find and remove scan the active ways;
// the next input beat is taken once the result is registered for output. The
// 4-bit-per-cycle modulo unit and the single slot memory port, read one way per cycle, set the item time.
// Synchronous active-high reset loads the register defaults and empties
// every bucket at once through per-bucket valid flags; there is no sweep.
module bucketed_hash_table (
  input logic       clk,
  input logic       rst,
  bht_in_if.sink    req,
  bht_out_if.source rsp,
  bht_cfg_if.sink   cfg
);
  import bht_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_ROW  = 6'b000100,
    S_DEC  = 6'b001000,
    S_SCAN = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state;

  logic [BCNT_W-1:0]  bucket_count;
  logic [IWAY_W-1:0]  initial_ways;
  logic [STEPC_W-1:0] ways_step;
  logic [WAYS_W-1:0]  active_ways;

  logic [OP_W-1:0]     op_q;
  logic [KEY_W-1:0]    key_q;
  logic [KEY_W-1:0]    name_q;
  logic [KEY_W-1:0]    ref_q;
  logic [BKT_W-1:0]    bucket;
  logic [MAX_WAYS-1:0] vbits;
  logic [WAYS_W-1:0]   rd_way;
  logic                cmp_pend;
  logic [WAY_W-1:0]    cmp_way;
  logic [STAT_W-1:0]   res_status;
  logic [KEY_W-1:0]    res_found;

  logic                out_valid;
  logic [STAT_W-1:0]   out_status;
  logic [KEY_W-1:0]    out_found;
  logic [WNOW_W-1:0]   out_ways;

  store_req_t          sreq;
  logic [MAX_WAYS-1:0] vrow;
  slot_t               slot_rdata;
  logic                mod_done;
  logic [REM_W-1:0]    mod_rem;

  logic                acc;
  logic                cfg_acc;
  logic                cfg_clear;
  logic [WAYS_W:0]     grow_sum;
  logic [WAYS_W-1:0]   grow_ways;
  logic [MAX_WAYS-1:0] empty_now;
  logic [MAX_WAYS-1:0] empty_grow;
  logic                can_grow;
  logic                add_ok;
  logic [WAY_W-1:0]    add_way;
  logic                hit;
  logic                ref_match;
  logic                last_cmp;
  logic                issue_rd;

  assign acc     = req.valid && req.ready;
  assign cfg_acc = cfg.valid && cfg.ready;
  assign cfg_clear = cfg_acc &&
                     (cfg.index == REG_BUCKET_COUNT || cfg.index == REG_INITIAL_WAYS);

  assign req.ready     = (state == S_IDLE);
  assign cfg.ready     = 1'b1;
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.found_ref = out_found;
  assign rsp.ways_now  = out_ways;

  bht_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (acc && req.op != OP_CLEAR),
    .dividend (req.key_hash),
    .divisor  (eff_buckets(bucket_count)),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  bht_store u_store (
    .clk        (clk),
    .rst        (rst),
    .req        (sreq),
    .row_rdata  (vrow),
    .slot_rdata (slot_rdata)
  );

  // Add: first empty way, else grow every bucket and take the first new way.
  always_comb begin
    empty_now = ~vrow & ways_mask(active_ways);
    grow_sum  = {1'b0, active_ways} +
                (WAYS_W + 1)'((ways_step == '0) ? STEPC_W'(1) : ways_step);
    grow_ways = (int'(grow_sum) > MAX_WAYS) ? WAYS_W'(MAX_WAYS) : grow_sum[WAYS_W-1:0];
    empty_grow = ~vrow & ways_mask(grow_ways);
    can_grow   = (int'(active_ways) < MAX_WAYS);
    add_ok     = (|empty_now) || (can_grow && (|empty_grow));
    add_way    = (|empty_now) ? first_way(empty_now) : first_way(empty_grow);
  end

  // Scan: the read issued for one way is compared in the next cycle.
  always_comb begin
    hit = cmp_pend && vbits[cmp_way] &&
          slot_rdata.key == key_q && slot_rdata.name_tag == name_q;
    ref_match = (slot_rdata.elem_ref == ref_q);
    last_cmp  = cmp_pend && (WAYS_W'(cmp_way) + WAYS_W'(1) == active_ways);
    issue_rd  = (state == S_SCAN) && !hit && (rd_way < active_ways);
  end

  always_comb begin
    sreq            = '0;
    sreq.clear      = (acc && req.op == OP_CLEAR) || cfg_clear;
    sreq.row_addr   = bucket;
    sreq.slot_wdata = '{key: key_q, name_tag: name_q, elem_ref: ref_q};
    sreq.slot_addr  = {bucket, rd_way[WAY_W-1:0]};
    sreq.row_rd     = (state == S_ROW);
    sreq.slot_rd    = issue_rd;
    if (state == S_DEC && op_q == OP_ADD && add_ok) begin
      sreq.row_wr    = 1'b1;
      sreq.row_wdata = vrow | way_bit(add_way);
      sreq.slot_wr   = 1'b1;
      sreq.slot_addr = {bucket, add_way};
    end
    if (state == S_SCAN && hit && op_q == OP_REMOVE && ref_match) begin
      sreq.row_wr    = 1'b1;
      sreq.row_wdata = vbits & ~way_bit(cmp_way);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      bucket_count <= BUCKET_COUNT_RST;
      initial_ways <= INITIAL_WAYS_RST;
      ways_step    <= WAYS_STEP_RST;
      active_ways  <= eff_initial(INITIAL_WAYS_RST);
      cmp_pend     <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (req.op == OP_CLEAR) begin
              res_status <= ST_OK;
              res_found  <= '0;
              state      <= S_OUT;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (mod_done) begin
            bucket <= mod_rem[BKT_W-1:0];
            state  <= S_ROW;
          end
        end
        S_ROW: begin
          state <= S_DEC;
        end
        S_DEC: begin
          vbits     <= vrow;
          res_found <= '0;
          if (op_q == OP_ADD) begin
            if (|empty_now) begin
              res_status <= ST_OK;
            end else if (!can_grow) begin
              res_status <= ST_FULL;
            end else begin
              active_ways <= grow_ways;
              res_status  <= add_ok ? ST_OK : ST_FULL;
            end
            state <= S_OUT;
          end else begin
            rd_way   <= '0;
            cmp_pend <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue_rd) begin
            rd_way   <= rd_way + WAYS_W'(1);
            cmp_pend <= 1'b1;
            cmp_way  <= rd_way[WAY_W-1:0];
          end else begin
            cmp_pend <= 1'b0;
          end
          if (hit) begin
            if (op_q == OP_FIND) begin
              res_status <= ST_OK;
              res_found  <= slot_rdata.elem_ref;
            end else begin
              res_status <= ref_match ? ST_OK : ST_MISS;
              res_found  <= '0;
            end
            state <= S_OUT;
          end else if (last_cmp) begin
            res_status <= ST_MISS;
            res_found  <= '0;
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (cfg_acc) begin
        unique case (cfg.index)
          REG_BUCKET_COUNT: begin
            bucket_count <= cfg.data[BCNT_W-1:0];
            active_ways  <= eff_initial(initial_ways);
          end
          REG_INITIAL_WAYS: begin
            initial_ways <= cfg.data[IWAY_W-1:0];
            active_ways  <= eff_initial(cfg.data[IWAY_W-1:0]);
          end
          REG_WAYS_STEP: ways_step <= cfg.data[STEPC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    if (acc) begin
      op_q   <= req.op;
      key_q  <= req.key_hash;
      name_q <= req.name_tag;
      ref_q  <= req.element_ref;
    end
    if (state == S_OUT && (!out_valid || rsp.ready)) begin
      out_status <= res_status;
      out_found  <= res_found;
      out_ways   <= WNOW_W'(active_ways);
    end
  end
endmodule

### rtl/bht_checker.sv
module bht_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [bht_pkg::STAT_W-1:0] status,
  input logic [bht_pkg::KEY_W-1:0]  found_ref,
  input logic [bht_pkg::WNOW_W-1:0] ways_now
);
  import bht_pkg::*;

  // No result beat may be left over from before reset.
  a_rst_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // Only one item is worked on at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("input taken while an item is in flight");

  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> found_ref == '0)
    else $error("handle reported on a failed item");

  a_ways_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ways_now != '0 && int'(ways_now) <= MAX_WAYS)
    else $error("way count out of range");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(found_ref)
      && $stable(ways_now))
    else $error("stalled result beat changed");
endmodule

bind bucketed_hash_table bht_checker u_bht_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .found_ref (rsp.found_ref),
  .ways_now  (rsp.ways_now)
);

### verif/tb_bucketed_hash_table.sv
`timescale 1ns / 1ps

module tb_bucketed_hash_table;
  import bht_pkg::*;

  localparam int TABLE_SLOTS = NUM_BUCKETS * MAX_WAYS;
  localparam int IDLE_LIMIT  = 3000;
  localparam int SINK_HOLD   = 250;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key_hash;
    logic [KEY_W-1:0] name_tag;
    logic [KEY_W-1:0] element_ref;
  } lookup_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  found_ref;
    logic [WNOW_W-1:0] ways_now;
  } lookup_rsp_t;

  // Keeps its own copy of the table and the registers, and the replies still owed.
  class table_scoreboard;
    bit                used [TABLE_SLOTS];
    logic [KEY_W-1:0]  keys [TABLE_SLOTS];
    logic [KEY_W-1:0]  names [TABLE_SLOTS];
    logic [KEY_W-1:0]  handles [TABLE_SLOTS];
    logic [BCNT_W-1:0] bucket_reg;
    logic [IWAY_W-1:0] init_reg;
    logic [STEPC_W-1:0] step_reg;
    int                ways;
    lookup_rsp_t       expected_rsp [$];
    int                errors;

    function new();
      bucket_reg = BUCKET_COUNT_RST;
      init_reg   = INITIAL_WAYS_RST;
      step_reg   = WAYS_STEP_RST;
      errors     = 0;
      empty_all();
      ways = start_ways();
    endfunction

    function void empty_all();
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    function int buckets_in_use();
      if (bucket_reg == '0) return 1;
      if (int'(bucket_reg) > NUM_BUCKETS) return NUM_BUCKETS;
      return int'(bucket_reg);
    endfunction

    function int start_ways();
      if (init_reg == '0) return 1;
      if (int'(init_reg) > MAX_WAYS) return MAX_WAYS;
      return int'(init_reg);
    endfunction

    function int base_of(logic [KEY_W-1:0] key);
      return int'(key % KEY_W'(buckets_in_use())) * MAX_WAYS;
    endfunction

    function int find_slot(logic [KEY_W-1:0] key, logic [KEY_W-1:0] name);
      int base;
      base = base_of(key);
      for (int w = 0; w < ways; w++) begin
        if (used[base + w] && keys[base + w] == key && names[base + w] == name) return base + w;
      end
      return -1;
    endfunction

    function bit place(lookup_req_t item);
      int base;
      base = base_of(item.key_hash);
      for (int w = 0; w < ways; w++) begin
        if (!used[base + w]) begin
          used[base + w]    = 1'b1;
          keys[base + w]    = item.key_hash;
          names[base + w]   = item.name_tag;
          handles[base + w] = item.element_ref;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_BUCKET_COUNT: begin
          bucket_reg = value[BCNT_W-1:0];
          empty_all();
          ways = start_ways();
        end
        REG_INITIAL_WAYS: begin
          init_reg = value[IWAY_W-1:0];
          empty_all();
          ways = start_ways();
        end
        REG_WAYS_STEP: begin
          step_reg = value[STEPC_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void note_request(lookup_req_t item);
      lookup_rsp_t reply;
      int slot;
      int grown;
      reply.status    = ST_OK;
      reply.found_ref = '0;
      case (item.op)
        OP_FIND: begin
          slot = find_slot(item.key_hash, item.name_tag);
          if (slot >= 0) reply.found_ref = handles[slot];
          else reply.status = ST_MISS;
        end
        OP_ADD: begin
          if (!place(item)) begin
            if (ways >= MAX_WAYS) begin
              reply.status = ST_FULL;
            end else begin
              // Growth applies to every bucket at once and then the add is retried.
              grown = ways + ((step_reg == '0) ? 1 : int'(step_reg));
              ways  = (grown > MAX_WAYS) ? MAX_WAYS : grown;
              if (!place(item)) reply.status = ST_FULL;
            end
          end
        end
        OP_REMOVE: begin
          slot = find_slot(item.key_hash, item.name_tag);
          if (slot >= 0 && handles[slot] == item.element_ref) used[slot] = 1'b0;
          else reply.status = ST_MISS;
        end
        OP_CLEAR: begin
          empty_all();
        end
      endcase
      reply.ways_now = WNOW_W'(ways);
      expected_rsp.push_back(reply);
    endfunction

    task report_mismatch(string msg);
      if (errors < 40) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(lookup_rsp_t got);
      lookup_rsp_t want;
      if (expected_rsp.size() == 0) begin
        report_mismatch($sformatf("reply beat with no request outstanding: %p", got));
      end else begin
        want = expected_rsp.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
        if (got.found_ref !== want.found_ref)
          report_mismatch($sformatf("found_ref %h, wanted %h", got.found_ref, want.found_ref));
        if (got.ways_now !== want.ways_now)
          report_mismatch($sformatf("ways_now %0d, wanted %0d", got.ways_now, want.ways_now));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   pace;
  bit   long_hold_req;
  int   idle_cycles;
  lookup_req_t placed [$];
  table_scoreboard board;

  bht_in_if  req_if ();
  bht_out_if rsp_if ();
  bht_cfg_if cfg_if ();

  bucketed_hash_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  always #4 clk = ~clk;

  function automatic int gap_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  task automatic send_item(input lookup_req_t item);
    int gap;
    gap = (pace && $urandom_range(0, 99) < 35) ? gap_len() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.op          <= item.op;
    req_if.key_hash    <= item.key_hash;
    req_if.name_tag    <= item.name_tag;
    req_if.element_ref <= item.element_ref;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    board.note_request(item);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    board.write_reg(idx, value);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (board.expected_rsp.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed traffic: lookups and removals of entries that were
  // added earlier, adds that pile into a few hot buckets, and some noise.
  function automatic lookup_req_t next_item();
    lookup_req_t item;
    lookup_req_t old;
    int pick;
    int roll;
    int nb;
    int hot;
    bit have;
    roll = $urandom_range(0, 99);
    nb   = board.buckets_in_use();
    hot  = $urandom_range(0, (nb < 4) ? nb - 1 : 3);
    item.element_ref = $urandom;
    item.name_tag    = $urandom;
    if ($urandom_range(0, 1)) item.key_hash = $urandom;
    else item.key_hash = KEY_W'(hot) + KEY_W'(nb) * KEY_W'($urandom_range(0, 65535));
    have = placed.size() > 0;
    pick = 0;
    if (have) begin
      pick = $urandom_range(0, placed.size() - 1);
      old  = placed[pick];
    end
    if (roll < 40) begin
      item.op = OP_ADD;
      if (have && $urandom_range(0, 4) == 0) begin
        item.key_hash = old.key_hash;
        if ($urandom_range(0, 1)) item.name_tag = old.name_tag;
      end
      placed.push_back(item);
      if (placed.size() > 48) void'(placed.pop_front());
    end else if (roll < 70) begin
      item.op = OP_FIND;
      if (have && $urandom_range(0, 9) < 7) begin
        item.key_hash = old.key_hash;
        if ($urandom_range(0, 9) != 0) item.name_tag = old.name_tag;
      end
    end else if (roll < 98) begin
      item.op = OP_REMOVE;
      if (have && $urandom_range(0, 9) < 7) begin
        item.key_hash = old.key_hash;
        item.name_tag = old.name_tag;
        if ($urandom_range(0, 4) != 0) item.element_ref = old.element_ref;
        placed.delete(pick);
      end
    end else begin
      item.op = OP_CLEAR;
      placed.delete();
    end
    return item;
  endfunction

  task automatic run_phase(input int count, input bit paced, input int pause_at, input int hold_at);
    pace = paced;
    placed.delete();
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) wait_drained();
      if (n == hold_at) long_hold_req = 1'b1;
      send_item(next_item());
    end
    wait_drained();
  endtask

  // Result side: checks each reply beat and paces ready.
  initial begin
    int stall_left;
    stall_left = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready)
        board.check_result('{rsp_if.status, rsp_if.found_ref, rsp_if.ways_now});
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = SINK_HOLD - 1;
        rsp_if.ready <= 1'b0;
      end else if (pace && $urandom_range(0, 99) < 25) begin
        stall_left    = gap_len() - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_bucketed_hash_table: FAIL");
      $finish;
    end
  end

  initial begin
    board              = new();
    idle_cycles        = 0;
    pace               = 1'b1;
    long_hold_req      = 1'b0;
    req_if.valid       = 1'b0;
    req_if.op          = OP_FIND;
    req_if.key_hash    = '0;
    req_if.name_tag    = '0;
    req_if.element_ref = '0;
    rsp_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_BUCKET_COUNT;
    cfg_if.data        = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed items on the reset settings: 256 buckets, four ways, step of two.
    send_item('{OP_FIND, 32'h0, 32'h0, 32'h0});
    send_item('{OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_item('{OP_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0});
    send_item('{OP_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0});
    send_item('{OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0});
    send_item('{OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_item('{OP_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0});
    send_item('{OP_ADD, 32'h0, 32'h0, 32'h0});
    send_item('{OP_FIND, 32'h0, 32'h0, 32'hFFFF_FFFF});
    // Ten adds into one bucket: growth to six, then to eight, then full twice.
    for (int i = 0; i < 10; i++)
      send_item('{OP_ADD, 32'h7 + 32'(i) * 32'd256, 32'h5A00 + 32'(i), 32'(i + 1)});
    send_item('{OP_ADD, 32'h0, 32'h0, 32'h5});
    send_item('{OP_FIND, 32'h707, 32'h5A07, 32'h0});
    send_item('{OP_REMOVE, 32'h907, 32'h5A09, 32'hA});
    send_item('{OP_CLEAR, 32'h0, 32'h0, 32'h0});
    send_item('{OP_FIND, 32'h7, 32'h5A00, 32'h0});
    wait_drained();

    // Zero in every register: one bucket, one way, a step of one.
    write_reg(REG_BUCKET_COUNT, 9'd0);
    write_reg(REG_INITIAL_WAYS, 9'd0);
    write_reg(REG_WAYS_STEP, 9'd0);
    cfg_if.valid <= 1'b0;
    run_phase(80, 1'b1, -1, 20);

    // The upper data bits are dropped for the four-bit registers.
    write_reg(REG_BUCKET_COUNT, 9'd3);
    write_reg(REG_INITIAL_WAYS, 9'h1F2);
    write_reg(REG_WAYS_STEP, 9'h103);
    cfg_if.valid <= 1'b0;
    run_phase(80, 1'b0, 40, -1);

    write_reg(REG_BUCKET_COUNT, 9'h1FF);
    write_reg(REG_INITIAL_WAYS, 9'd15);
    write_reg(REG_WAYS_STEP, 9'd15);
    cfg_if.valid <= 1'b0;
    run_phase(80, 1'b1, -1, -1);

    write_reg(REG_BUCKET_COUNT, 9'd16);
    write_reg(REG_INITIAL_WAYS, 9'd1);
    write_reg(REG_WAYS_STEP, 9'd8);
    cfg_if.valid <= 1'b0;
    run_phase(80, 1'b1, -1, -1);

    // A step change keeps the table contents; the spare index does nothing.
    write_reg(REG_WAYS_STEP, 9'd4);
    write_reg(REG_SPARE, 9'h1FF);
    cfg_if.valid <= 1'b0;
    run_phase(80, 1'b1, -1, -1);

    write_reg(REG_BUCKET_COUNT, 9'd256);
    write_reg(REG_INITIAL_WAYS, 9'd8);
    write_reg(REG_WAYS_STEP, 9'd1);
    cfg_if.valid <= 1'b0;
    run_phase(80, 1'b1, -1, -1);

    repeat (32) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb_bucketed_hash_table: PASS");
    end else begin
      $display("tb_bucketed_hash_table: FAIL");
    end
    $finish;
  end

endmodule
